FILE: src/c2s_pkg.sv
package c2s_pkg;

  localparam int CORDIC_STAGES = 20;

  localparam int COORD_W   = 32;
  localparam int REFL_W    = 8;
  localparam int RANGE_W   = 36;
  localparam int POLAR_W   = 18;
  localparam int AZIM_W    = 19;

  // square sums and restoring square root
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 36;
  localparam int REM_W      = 38;
  localparam int ROOT_STEPS = 36;
  localparam int FRAC_PAIRS = 4;

  // vectoring datapath
  localparam int LANE_IN_W = 37;
  localparam int CW        = 60;
  localparam int ACC_W     = 28;
  localparam int ANG_PRE   = 20;
  localparam int ROUND_SH  = 8;

  localparam logic signed [ACC_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ACC_W-1:0] ROUND_HALF  = 28'sd128;
  localparam int PI_Q16 = 205887;

  localparam int SQ_LAT    = 4;
  localparam int SQRT_LAT  = ROOT_STEPS;
  localparam int LANE_LAT  = CORDIC_STAGES + 2;
  localparam int TOTAL_LAT = SQ_LAT + SQRT_LAT + LANE_LAT + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [REFL_W-1:0]         refl;
    logic                      last;
  } point_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  // one restoring step: bring down a radicand bit pair, try to subtract
  function automatic root_t root_step(root_t cur, logic [1:0] pair);
    root_t nxt;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    r     = {cur.rem[REM_W-3:0], pair};
    trial = {cur.root, 2'b01};
    if (r >= trial) begin
      nxt.rem  = r - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = r;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // atan(2^-i) with 24 fraction bits, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_q24(int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      24: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/c2s_square.sv
module c2s_square (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  c2s_pkg::point_t          in_pt,
  output logic                     out_valid,
  output c2s_pkg::point_t          out_pt,
  output logic [c2s_pkg::SQ_W-1:0] out_s,
  output logic [c2s_pkg::SQ_W-1:0] out_sxy
);

  logic [c2s_pkg::COORD_W-1:0] ax1, ay1, az1;
  logic [c2s_pkg::SQ_W-1:0]    sqx2, sqy2, sqz2, sxy3, sqz3;
  c2s_pkg::point_t             pt1, pt2, pt3;
  logic                        v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // magnitudes: the most negative code maps to 2^31, still fits unsigned
    ax1 <= in_pt.x[c2s_pkg::COORD_W-1] ? c2s_pkg::COORD_W'(-in_pt.x) : in_pt.x;
    ay1 <= in_pt.y[c2s_pkg::COORD_W-1] ? c2s_pkg::COORD_W'(-in_pt.y) : in_pt.y;
    az1 <= in_pt.z[c2s_pkg::COORD_W-1] ? c2s_pkg::COORD_W'(-in_pt.z) : in_pt.z;
    pt1 <= in_pt;
    sqx2 <= ax1 * ax1;
    sqy2 <= ay1 * ay1;
    sqz2 <= az1 * az1;
    pt2  <= pt1;
    sxy3 <= sqx2 + sqy2;
    sqz3 <= sqz2;
    pt3  <= pt2;
    out_s   <= sxy3 + sqz3;
    out_sxy <= sxy3;
    out_pt  <= pt3;
  end

endmodule

FILE: src/c2s_sqrt.sv
module c2s_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  c2s_pkg::point_t            in_pt,
  input  logic [c2s_pkg::SQ_W-1:0]   in_s,
  input  logic [c2s_pkg::SQ_W-1:0]   in_sxy,
  output logic                       out_valid,
  output c2s_pkg::point_t            out_pt,
  output logic [c2s_pkg::ROOT_W-1:0] range,
  output logic [c2s_pkg::ROOT_W-1:0] horiz
);

  localparam int N = c2s_pkg::ROOT_STEPS;

  c2s_pkg::root_t           rng_st [N];
  c2s_pkg::root_t           hz_st  [N];
  logic [c2s_pkg::SQ_W-1:0] s_st   [N];
  logic [c2s_pkg::SQ_W-1:0] sxy_st [N];
  c2s_pkg::point_t          pt_st  [N];
  logic                     v_st   [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int K = N - 1 - j;
    c2s_pkg::root_t           rc, hc;
    logic [c2s_pkg::SQ_W-1:0] sc, sxyc;
    c2s_pkg::point_t          pc;
    logic                     vc;
    logic [1:0]               pr, ph;

    if (j == 0) begin : g_first
      assign rc   = '0;
      assign hc   = '0;
      assign sc   = in_s;
      assign sxyc = in_sxy;
      assign pc   = in_pt;
      assign vc   = in_valid;
    end else begin : g_next
      assign rc   = rng_st[j-1];
      assign hc   = hz_st[j-1];
      assign sc   = s_st[j-1];
      assign sxyc = sxy_st[j-1];
      assign pc   = pt_st[j-1];
      assign vc   = v_st[j-1];
    end

    // the last pairs are the zero fraction bits of the scaled radicand
    if (K >= c2s_pkg::FRAC_PAIRS) begin : g_pair
      assign pr = sc[2*(K-c2s_pkg::FRAC_PAIRS)+1 -: 2];
      assign ph = sxyc[2*(K-c2s_pkg::FRAC_PAIRS)+1 -: 2];
    end else begin : g_frac
      assign pr = 2'b00;
      assign ph = 2'b00;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_st[j] <= 1'b0;
      end else begin
        v_st[j] <= vc;
      end
    end

    always_ff @(posedge clk) begin
      rng_st[j] <= c2s_pkg::root_step(rc, pr);
      hz_st[j]  <= c2s_pkg::root_step(hc, ph);
      s_st[j]   <= sc;
      sxy_st[j] <= sxyc;
      pt_st[j]  <= pc;
    end
  end

  assign out_valid = v_st[N-1];
  assign out_pt    = pt_st[N-1];
  assign range     = rng_st[N-1].root;
  assign horiz     = hz_st[N-1].root;

endmodule

FILE: src/c2s_cordic.sv
module c2s_cordic (
  input  logic                                 clk,
  input  logic signed [c2s_pkg::LANE_IN_W-1:0] a_in,
  input  logic signed [c2s_pkg::LANE_IN_W-1:0] b_in,
  output logic signed [c2s_pkg::AZIM_W-1:0]    ang
);

  localparam int N  = c2s_pkg::CORDIC_STAGES;
  localparam int CW = c2s_pkg::CW;
  localparam int AW = c2s_pkg::ACC_W;

  logic signed [CW-1:0] a_s, b_s, a_pre, b_pre;
  logic signed [AW-1:0] acc_pre, rnd;
  logic                 zero_in;

  logic signed [CW-1:0] a_st   [N+1];
  logic signed [CW-1:0] b_st   [N+1];
  logic signed [AW-1:0] acc_st [N+1];
  logic                 z_st   [N+1];

  // scale, then fold the left half plane onto the right one
  always_comb begin
    a_s     = CW'(a_in) <<< c2s_pkg::ANG_PRE;
    b_s     = CW'(b_in) <<< c2s_pkg::ANG_PRE;
    zero_in = (a_in == '0) && (b_in == '0);
    if (a_s[CW-1]) begin
      if (!b_s[CW-1]) begin
        a_pre   = b_s;
        b_pre   = -a_s;
        acc_pre = c2s_pkg::HALF_PI_Q24;
      end else begin
        a_pre   = -b_s;
        b_pre   = a_s;
        acc_pre = -c2s_pkg::HALF_PI_Q24;
      end
    end else begin
      a_pre   = a_s;
      b_pre   = b_s;
      acc_pre = '0;
    end
  end

  always_ff @(posedge clk) begin
    a_st[0]   <= a_pre;
    b_st[0]   <= b_pre;
    acc_st[0] <= acc_pre;
    z_st[0]   <= zero_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CW-1:0] da, db;
    assign da = b_st[i] >>> i;
    assign db = a_st[i] >>> i;

    always_ff @(posedge clk) begin
      if (!b_st[i][CW-1]) begin
        a_st[i+1]   <= a_st[i] + da;
        b_st[i+1]   <= b_st[i] - db;
        acc_st[i+1] <= acc_st[i] + c2s_pkg::atan_q24(i);
      end else begin
        a_st[i+1]   <= a_st[i] - da;
        b_st[i+1]   <= b_st[i] + db;
        acc_st[i+1] <= acc_st[i] - c2s_pkg::atan_q24(i);
      end
      z_st[i+1] <= z_st[i];
    end
  end

  assign rnd = (acc_st[N] + c2s_pkg::ROUND_HALF) >>> c2s_pkg::ROUND_SH;

  always_ff @(posedge clk) begin
    if (z_st[N]) begin
      ang <= '0;
    end else if (rnd > AW'(c2s_pkg::PI_Q16)) begin
      ang <= c2s_pkg::AZIM_W'(c2s_pkg::PI_Q16);
    end else if (rnd < -AW'(c2s_pkg::PI_Q16)) begin
      ang <= -c2s_pkg::AZIM_W'(c2s_pkg::PI_Q16);
    end else begin
      ang <= c2s_pkg::AZIM_W'(rnd);
    end
  end

endmodule

FILE: src/cartesian_to_spherical.sv
// Channel   Ports                                          Handshake
// input     x_mm, y_mm, z_mm, refl_in, last_in             start high, busy low
// result    range_q4, polar_q16, azimuth_q16, refl_out,    done high one cycle
//           last_out
//
// One point enters per cycle; busy stays low, so every start is a transfer.
// A point passes through the squares, the root unit (one radicand bit pair
// per stage), the vectoring lanes and the result register.
// Reset (rst, synchronous) drops every valid bit in flight; payload is kept.
// The receiver cannot stall, so the pipeline never holds.
module cartesian_to_spherical (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [c2s_pkg::COORD_W-1:0]  x_mm,
  input  logic signed [c2s_pkg::COORD_W-1:0]  y_mm,
  input  logic signed [c2s_pkg::COORD_W-1:0]  z_mm,
  input  logic        [c2s_pkg::REFL_W-1:0]   refl_in,
  input  logic                                last_in,
  output logic                                done,
  output logic        [c2s_pkg::RANGE_W-1:0]  range_q4,
  output logic        [c2s_pkg::POLAR_W-1:0]  polar_q16,
  output logic signed [c2s_pkg::AZIM_W-1:0]   azimuth_q16,
  output logic        [c2s_pkg::REFL_W-1:0]   refl_out,
  output logic                                last_out
);

  localparam int L = c2s_pkg::LANE_LAT;

  c2s_pkg::point_t             pt_in, sq_pt, rt_pt;
  logic                        accept, sq_valid, rt_valid;
  logic [c2s_pkg::SQ_W-1:0]    sq_s, sq_sxy;
  logic [c2s_pkg::ROOT_W-1:0]  rt_range, rt_horiz;

  logic signed [c2s_pkg::LANE_IN_W-1:0] pol_a, pol_b, az_a, az_b;
  logic signed [c2s_pkg::AZIM_W-1:0]    pol_ang, az_ang;

  // sideband delay matching the vectoring lanes
  logic                         dl_v     [L];
  logic [c2s_pkg::RANGE_W-1:0]  dl_range [L];
  logic [c2s_pkg::REFL_W-1:0]   dl_refl  [L];
  logic                         dl_last  [L];

  // never stall: the whole datapath advances every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pt_in.x    = x_mm;
  assign pt_in.y    = y_mm;
  assign pt_in.z    = z_mm;
  assign pt_in.refl = refl_in;
  assign pt_in.last = last_in;

  c2s_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_pt     (pt_in),
    .out_valid (sq_valid),
    .out_pt    (sq_pt),
    .out_s     (sq_s),
    .out_sxy   (sq_sxy)
  );

  // range and horizontal length run side by side in one pipelined root unit
  c2s_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_pt     (sq_pt),
    .in_s      (sq_s),
    .in_sxy    (sq_sxy),
    .out_valid (rt_valid),
    .out_pt    (rt_pt),
    .range     (rt_range),
    .horiz     (rt_horiz)
  );

  // lane vectors carry 4 fraction bits: (16z, h) and (16x, 16y)
  assign pol_a = {rt_pt.z[c2s_pkg::COORD_W-1], rt_pt.z, 4'b0000};
  assign pol_b = {1'b0, rt_horiz};
  assign az_a  = {rt_pt.x[c2s_pkg::COORD_W-1], rt_pt.x, 4'b0000};
  assign az_b  = {rt_pt.y[c2s_pkg::COORD_W-1], rt_pt.y, 4'b0000};

  c2s_cordic u_polar (
    .clk  (clk),
    .a_in (pol_a),
    .b_in (pol_b),
    .ang  (pol_ang)
  );

  c2s_cordic u_azim (
    .clk  (clk),
    .a_in (az_a),
    .b_in (az_b),
    .ang  (az_ang)
  );

  for (genvar k = 0; k < L; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_v[k] <= 1'b0;
      end else begin
        dl_v[k] <= (k == 0) ? rt_valid : dl_v[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        dl_range[k] <= rt_range;
        dl_refl[k]  <= rt_pt.refl;
        dl_last[k]  <= rt_pt.last;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        dl_range[k] <= dl_range[k-1];
        dl_refl[k]  <= dl_refl[k-1];
        dl_last[k]  <= dl_last[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dl_v[L-1];
    end
  end

  // polar angle cannot be negative: clamp to zero, drop the sign bit
  always_ff @(posedge clk) begin
    range_q4    <= dl_range[L-1];
    polar_q16   <= pol_ang[c2s_pkg::AZIM_W-1] ? '0 : pol_ang[c2s_pkg::POLAR_W-1:0];
    azimuth_q16 <= az_ang;
    refl_out    <= dl_refl[L-1];
    last_out    <= dl_last[L-1];
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(c2s_pkg::TOTAL_LAT) done)
    else $error("transfer did not produce a result on time");

  a_polar_rng : assert property (@(posedge clk) disable iff (rst)
    done |-> (polar_q16 <= c2s_pkg::PI_Q16))
    else $error("polar angle out of range");

  a_azim_rng : assert property (@(posedge clk) disable iff (rst)
    done |-> (azimuth_q16 <= c2s_pkg::PI_Q16) && (azimuth_q16 >= -c2s_pkg::PI_Q16))
    else $error("azimuth out of range");

  a_zero_rng : assert property (@(posedge clk) disable iff (rst)
    (done && (range_q4 == '0)) |-> (polar_q16 == '0) && (azimuth_q16 == '0))
    else $error("nonzero angle at zero range");

endmodule

FILE: sim/c2s_checker.sv
module c2s_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [c2s_pkg::COORD_W-1:0]  x_mm,
  input  logic signed [c2s_pkg::COORD_W-1:0]  y_mm,
  input  logic signed [c2s_pkg::COORD_W-1:0]  z_mm,
  input  logic        [c2s_pkg::REFL_W-1:0]   refl_in,
  input  logic                                last_in,
  input  logic                                done,
  input  logic        [c2s_pkg::RANGE_W-1:0]  range_q4,
  input  logic        [c2s_pkg::POLAR_W-1:0]  polar_q16,
  input  logic signed [c2s_pkg::AZIM_W-1:0]   azimuth_q16,
  input  logic        [c2s_pkg::REFL_W-1:0]   refl_out,
  input  logic                                last_out,
  output int                                  errors,
  output int                                  pending
);
  import c2s_pkg::*;

  typedef struct packed {
    logic [RANGE_W-1:0]        range;
    logic [POLAR_W-1:0]        polar;
    logic signed [AZIM_W-1:0]  azim;
    logic [REFL_W-1:0]         refl;
    logic                      last;
  } sph_t;

  sph_t sph_q[$];

  localparam longint ATAN_TBL [32] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  // floor(sqrt(s * 256)), s up to 3 * 2^62
  function automatic longint unsigned root_q4(logic [65:0] s);
    logic [71:0] rad;
    logic [71:0] rem, root, trial;
    rad = {6'd0, s} << 8;
    rem = '0;
    root = '0;
    for (int k = 35; k >= 0; k--) begin
      rem = (rem << 2) | ((rad >> (2 * k)) & 72'd3);
      trial = (root << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 72'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  // atan2(b, a) in Q16; inputs carry 4 fraction bits
  function automatic longint vec_angle(longint a, longint b);
    longint acc, t, da, db;
    acc = 0;
    if (a == 0 && b == 0) return 0;
    a = a * (64'sd1 <<< 20);
    b = b * (64'sd1 <<< 20);
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; acc = HALF_PI_Q24;
      end else begin
        a = -b; b = t; acc = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      da = fshr(b, i);
      db = fshr(a, i);
      if (b >= 0) begin
        a += da; b -= db; acc += ATAN_TBL[i];
      end else begin
        a -= da; b += db; acc -= ATAN_TBL[i];
      end
    end
    acc = fshr(acc + 128, 8);
    if (acc > PI_Q16) acc = PI_Q16;
    if (acc < -PI_Q16) acc = -PI_Q16;
    return acc;
  endfunction

  function automatic sph_t to_spherical(longint x, longint y, longint z,
                                        logic [REFL_W-1:0] refl, logic last);
    sph_t r;
    logic [65:0] sxy, sall;
    longint unsigned rng, h;
    longint pol, az;
    sxy = 66'(x * x) + 66'(y * y);
    sall = sxy + 66'(z * z);
    rng = root_q4(sall);
    pol = 0;
    az = 0;
    if (rng != 0) begin
      h = root_q4(sxy);
      pol = vec_angle(z * 16, longint'(h));
      if (pol < 0) pol = 0;
      az = vec_angle(x * 16, y * 16);
    end
    r.range = rng[RANGE_W-1:0];
    r.polar = pol[POLAR_W-1:0];
    r.azim = az[AZIM_W-1:0];
    r.refl = refl;
    r.last = last;
    return r;
  endfunction

  assign pending = sph_q.size();

  // Predict on each input transfer, compare on each result strobe.
  always @(posedge clk) begin
    sph_t got, exp_r;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy)
        sph_q.push_back(to_spherical(longint'(x_mm), longint'(y_mm), longint'(z_mm),
                                     refl_in, last_in));
      if (done) begin
        got = '{range_q4, polar_q16, azimuth_q16, refl_out, last_out};
        if (sph_q.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = sph_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t mismatch range exp %0d act %0d", $time, exp_r.range, got.range);
            $display("%0t   polar exp %0d act %0d", $time, exp_r.polar, got.polar);
            $display("%0t   azim exp %0d act %0d", $time, exp_r.azim, got.azim);
            $display("%0t   refl exp %0d act %0d last exp %0d act %0d", $time,
                     exp_r.refl, got.refl, exp_r.last, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/tb_top.sv
module tb_top;
  import c2s_pkg::*;

  localparam int DRAIN = TOTAL_LAT + 20;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 1780;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] x_mm = '0, y_mm = '0, z_mm = '0;
  logic [REFL_W-1:0] refl_in = '0;
  logic last_in = 1'b0;
  logic done;
  logic [RANGE_W-1:0] range_q4;
  logic [POLAR_W-1:0] polar_q16;
  logic signed [AZIM_W-1:0] azimuth_q16;
  logic [REFL_W-1:0] refl_out;
  logic last_out;
  int errors, pending;
  int idle_cycles = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  cartesian_to_spherical u_top (.*);

  c2s_checker u_chk (.*);

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one point and hold it until the transfer; random gaps first unless calm.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [7:0] r, logic l);
    while (!calm && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    x_mm <= x; y_mm <= y; z_mm <= z; refl_in <= r; last_in <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix small lidar-like values with full-width extremes.
  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(3);
      2: return 32'($signed($urandom_range(4)) - 2);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: zero range, axes, quadrants, extremes
    send_point(0, 0, 0, 8'h00, 1'b0);
    send_point(0, 0, 5, 8'hff, 1'b1);
    send_point(0, 0, -5, 8'h55, 1'b0);
    send_point(7, 0, 0, 8'haa, 1'b0);
    send_point(-7, 0, 0, 8'h01, 1'b1);
    send_point(0, 7, 0, 8'h80, 1'b0);
    send_point(0, -7, 0, 8'h7f, 1'b0);
    send_point(-3, -4, 0, 8'h10, 1'b0);
    send_point(-3, 4, 2, 8'h20, 1'b0);
    send_point(3, -4, -2, 8'h40, 1'b0);
    send_point(mx, mx, mx, 8'hff, 1'b1);
    send_point(mn, mn, mn, 8'h00, 1'b0);
    send_point(mn, 0, 0, 8'h0f, 1'b0);
    send_point(0, mn, mx, 8'hf0, 1'b1);
    send_point(mx, mn, 0, 8'h3c, 1'b0);
    send_point(-1, -1, -1, 8'hc3, 1'b0);
    send_point(1, 1, 1, 8'h99, 1'b1);
    send_point(mn, 1, -1, 8'h66, 1'b0);
    send_point(1000, -1, mn, 8'h11, 1'b0);
    send_point(-1, 0, 0, 8'h22, 1'b0);
    // hold off until the pipeline is empty
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 900);
      send_point(coord(), coord(), coord(), 8'($urandom), 1'($urandom));
      if (i == 1200) begin
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
src/c2s_pkg.sv
src/c2s_square.sv
src/c2s_sqrt.sv
src/c2s_cordic.sv
src/cartesian_to_spherical.sv
sim/c2s_checker.sv
sim/tb_top.sv
